### design/mfvn_pkg.sv
// ----------------------------------------------------------------------------
// mfvn_pkg: shared constants, types and helpers for the mesh normal block
// Widths of the item fields, the face count limit and the divider handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package mfvn_pkg;

  // Block limits
  localparam int MAX_FACES   = 64;
  localparam int COORD_WIDTH = 24;
  localparam int FC_W        = $clog2(MAX_FACES + 1);

  // Field and datapath widths
  localparam int CRD_W   = 24;
  localparam int OUT_W   = 18;
  localparam int ACC_W   = 53;
  localparam int MAG_W   = 52;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 66;
  localparam int QUO_W   = 25;
  localparam int DEN_W   = 32;
  localparam int STEPS_W = 5;
  localparam int CFG_W   = 32;
  localparam int FMIN_W  = 32;
  localparam int VMIN_W  = 17;

  // Divider step counts
  localparam int VDIV_STEPS = 25;
  localparam int NDIV_STEPS = 17;

  // Register indexes
  localparam logic REG_FACE_MIN = 1'b0;
  localparam logic REG_VERT_MIN = 1'b1;

  // Opcodes and result kinds
  localparam logic OP_FACE   = 1'b0;
  localparam logic OP_VERT   = 1'b1;
  localparam logic KIND_FACE = 1'b0;
  localparam logic KIND_VERT = 1'b1;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [STEPS_W-1:0] steps;
    logic [DEN_W-1:0]   rem_init;
    logic [QUO_W-1:0]   low_init;
    logic [DEN_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Sign-extend a vertex coordinate from its low COORD_WIDTH bits
  function automatic logic signed [CRD_W-1:0] sext_coord(input logic [CRD_W-1:0] v);
    logic signed [CRD_W-1:0] t;
    t = $signed(v << (CRD_W - COORD_WIDTH));
    return t >>> (CRD_W - COORD_WIDTH);
  endfunction

endpackage

`default_nettype wire

### design/mfvn_chan_if.sv
// ----------------------------------------------------------------------------
// mfvn channel interfaces
// Input item channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfvn_in_if import mfvn_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [CRD_W-1:0] ax;
  logic signed [CRD_W-1:0] ay;
  logic signed [CRD_W-1:0] az;
  logic signed [CRD_W-1:0] bx;
  logic signed [CRD_W-1:0] by_coord;
  logic signed [CRD_W-1:0] bz;
  logic signed [CRD_W-1:0] cx;
  logic signed [CRD_W-1:0] cy;
  logic signed [CRD_W-1:0] cz;
  logic                    last_face;

  modport source (output valid, opcode, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                  last_face, input ready);
  modport sink (input valid, opcode, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                last_face, output ready);
endinterface

interface mfvn_out_if import mfvn_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] norm_x;
  logic signed [OUT_W-1:0] norm_y;
  logic signed [OUT_W-1:0] norm_z;
  logic                    kind;
  logic                    not_normalized;
  logic                    count_overflow;

  modport source (output valid, norm_x, norm_y, norm_z, kind, not_normalized,
                  count_overflow, input ready);
  modport sink (input valid, norm_x, norm_y, norm_z, kind, not_normalized,
                count_overflow, output ready);
endinterface

`default_nettype wire

### design/mfvn_div.sv
// ----------------------------------------------------------------------------
// mfvn_div: restoring divider, one quotient bit per cycle
// Remainder is preloaded with the high part of the dividend; the low part
// is shifted in from the top of low_init for the requested number of steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mfvn_div import mfvn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r;
  logic               done_r;
  logic [STEPS_W-1:0] cnt_r;
  logic [DEN_W-1:0]   rem_r;
  logic [QUO_W-1:0]   low_r;
  logic [QUO_W-1:0]   quo_r;
  logic [DEN_W-1:0]   den_r;

  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               ge;

  // one trial subtraction
  assign trial = {rem_r, low_r[QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEPS_W'(1);
        if (cnt_r == STEPS_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      low_r <= req.low_init;
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

### design/mesh_face_and_vertex_normals_top.sv
// ----------------------------------------------------------------------------
// Faces are passed raw or normalised. A vertex beat without last_face only adds
// to the running sums; a vertex beat with last_face is averaged, then passed raw
// or normalised (three 25-step averaging divisions first).
// One item at a time, through the shared 33x33 multiplier, the bit-serial square root
// (32 steps) and the one-bit-per-cycle divider. Synchronous active-low reset clears
// control, running sums and the output valid, and loads the default thresholds.
// ----------------------------------------------------------------------------
// mesh_face_and_vertex_normals_top
// Newell face normal and averaged vertex normal, normalised to Q1.16 above a threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_face_and_vertex_normals_top import mfvn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [CFG_W-1:0]  cfg_wdata,
  mfvn_in_if.sink           in_ch,
  mfvn_out_if.source        out_ch
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_NMUL = 11'b00000000010,
    ST_VDIV = 11'b00000000100,
    ST_MAG  = 11'b00000001000,
    ST_THR  = 11'b00000010000,
    ST_DEC  = 11'b00000100000,
    ST_SHF  = 11'b00001000000,
    ST_SQ   = 11'b00010000000,
    ST_SQRT = 11'b00100000000,
    ST_NDIV = 11'b01000000000,
    ST_FIN  = 11'b10000000000
  } state_t;

  localparam int SHF_LIM = 30;
  localparam int BIG_LIM = 32;

  // vertex slots in the coordinate array
  localparam int X0 = 0, Y0 = 1, Z0 = 2, X1 = 3, Y1 = 4, Z1 = 5, X2 = 6, Y2 = 7, Z2 = 8;

  state_t                   state_r;
  logic [FMIN_W-1:0]        face_min_r;
  logic [VMIN_W-1:0]        vert_min_r;

  logic signed [CRD_W-1:0]  crd_r [9];
  logic signed [ACC_W-1:0]  comp_r [3];
  logic [MAG_W-1:0]         mag_r [3];
  logic [1:0]               k_r;
  logic [1:0]               edge_r;
  logic                     ph_r;
  logic                     big_r;
  logic                     kind_r;
  logic                     ovf_r;
  logic                     raw_r;
  logic                     launched_r;
  logic [PROD_W-1:0]        sq_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [63:0]              root_r;
  logic [63:0]              bit_r;
  logic [FC_W-1:0]          n_r;
  logic [OUT_W-1:0]         res_r [3];

  // running vertex state
  logic signed [CRD_W-1:0]  sum_r [3];
  logic [FC_W-1:0]          fc_r;
  logic                     ovfs_r;

  // result register
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_n_r [3];
  logic                     out_kind_r;
  logic                     out_raw_r;
  logic                     out_ovf_r;

  logic                     in_beat;
  logic                     out_free;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [CRD_W-1:0] sat_add(input logic signed [CRD_W-1:0] a,
                                                      input logic signed [CRD_W-1:0] b);
    logic signed [CRD_W:0] s;
    s = {a[CRD_W-1], a} + {b[CRD_W-1], b};
    if (s[CRD_W] != s[CRD_W-1]) begin
      return s[CRD_W] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
    end
    return s[CRD_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] magn(input logic signed [ACC_W-1:0] c);
    logic [ACC_W-1:0] m;
    m = c[ACC_W-1] ? -c : c;
    return m[MAG_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] apply_sign(input logic neg, input logic [OUT_W-1:0] v);
    return neg ? -v : v;
  endfunction

  // raw pass: rounding into Q1.16 for faces, saturation for both kinds
  function automatic logic [OUT_W-1:0] raw_out(input logic neg, input logic [MAG_W-1:0] m,
                                               input logic kind);
    logic [MAG_W:0] r;
    r = (kind == KIND_VERT) ? {1'b0, m} : (({1'b0, m} + (MAG_W+1)'(128)) >> 8);
    if (r > (MAG_W+1)'(65536)) r = (MAG_W+1)'(65536);
    return apply_sign(neg, r[OUT_W-1:0]);
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_min_r <= FMIN_W'(17);
      vert_min_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FACE_MIN: face_min_r <= cfg_wdata[FMIN_W-1:0];
        REG_VERT_MIN: vert_min_r <= cfg_wdata[VMIN_W-1:0];
        default:      face_min_r <= face_min_r;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // ---------------------------------------------------------------- Newell operands
  logic signed [CRD_W-1:0] da, db, sa, sb;
  always_comb begin
    case ({k_r, edge_r})
      4'b0000: begin da = crd_r[Y2]; db = crd_r[Y0]; sa = crd_r[Z2]; sb = crd_r[Z0]; end
      4'b0001: begin da = crd_r[Y0]; db = crd_r[Y1]; sa = crd_r[Z0]; sb = crd_r[Z1]; end
      4'b0010: begin da = crd_r[Y1]; db = crd_r[Y2]; sa = crd_r[Z1]; sb = crd_r[Z2]; end
      4'b0100: begin da = crd_r[Z2]; db = crd_r[Z0]; sa = crd_r[X2]; sb = crd_r[X0]; end
      4'b0101: begin da = crd_r[Z0]; db = crd_r[Z1]; sa = crd_r[X0]; sb = crd_r[X1]; end
      4'b0110: begin da = crd_r[Z1]; db = crd_r[Z2]; sa = crd_r[X1]; sb = crd_r[X2]; end
      4'b1000: begin da = crd_r[X2]; db = crd_r[X0]; sa = crd_r[Y2]; sb = crd_r[Y0]; end
      4'b1001: begin da = crd_r[X0]; db = crd_r[X1]; sa = crd_r[Y0]; sb = crd_r[Y1]; end
      4'b1010: begin da = crd_r[X1]; db = crd_r[X2]; sa = crd_r[Y1]; sb = crd_r[Y2]; end
      default: begin da = '0; db = '0; sa = '0; sb = '0; end
    endcase
  end

  logic signed [CRD_W:0] nw_d, nw_s;
  assign nw_d = {da[CRD_W-1], da} - {db[CRD_W-1], db};
  assign nw_s = {sa[CRD_W-1], sa} + {sb[CRD_W-1], sb};

  // ---------------------------------------------------------------- shared multiplier
  logic [MAG_W-1:0]        mag_sel;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    case (k_r)
      2'd0:    mag_sel = mag_r[0];
      2'd1:    mag_sel = mag_r[1];
      2'd2:    mag_sel = mag_r[2];
      default: mag_sel = '0;
    endcase
  end

  always_comb begin
    mul_a = {1'b0, mag_sel[31:0]};
    mul_b = {1'b0, mag_sel[31:0]};
    if (state_r == ST_NMUL) begin
      mul_a = MUL_W'(nw_d);
      mul_b = MUL_W'(nw_s);
    end else if (state_r == ST_THR && k_r == 2'd3) begin
      mul_a = (kind_r == KIND_VERT) ? MUL_W'(vert_min_r) : MUL_W'(face_min_r);
      mul_b = mul_a;
    end
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------- divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [DEN_W-1:0] len;
  logic [46:0]      ndiv_num;
  logic [QUO_W-1:0] vdiv_num;
  logic             cur_neg;

  assign len      = (root_r[DEN_W-1:0] == '0) ? DEN_W'(1) : root_r[DEN_W-1:0];
  assign ndiv_num = {1'b0, mag_sel[SHF_LIM-1:0], 16'b0} + 47'(len >> 1);
  assign vdiv_num = QUO_W'(mag_sel[CRD_W-1:0]) + QUO_W'(n_r >> 1);

  always_comb begin
    case (k_r)
      2'd0:    cur_neg = comp_r[0][ACC_W-1];
      2'd1:    cur_neg = comp_r[1][ACC_W-1];
      default: cur_neg = comp_r[2][ACC_W-1];
    endcase
  end

  always_comb begin
    div_req.start = ((state_r == ST_NDIV) || (state_r == ST_VDIV)) && !launched_r;
    if (state_r == ST_NDIV) begin
      div_req.steps    = STEPS_W'(NDIV_STEPS);
      div_req.rem_init = DEN_W'(ndiv_num[46:NDIV_STEPS]);
      div_req.low_init = {ndiv_num[NDIV_STEPS-1:0], (QUO_W-NDIV_STEPS)'(0)};
      div_req.den      = len;
    end else begin
      div_req.steps    = STEPS_W'(VDIV_STEPS);
      div_req.rem_init = '0;
      div_req.low_init = vdiv_num;
      div_req.den      = DEN_W'(n_r);
    end
  end

  mfvn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------- vertex accumulate
  logic signed [CRD_W-1:0] sum_nxt [3];
  logic [FC_W-1:0]         fc_nxt;
  logic                    ovfs_nxt;
  logic                    fc_full;

  assign sum_nxt[0] = sat_add(sum_r[0], in_ch.ax);
  assign sum_nxt[1] = sat_add(sum_r[1], in_ch.ay);
  assign sum_nxt[2] = sat_add(sum_r[2], in_ch.az);
  assign fc_full    = fc_r >= FC_W'(MAX_FACES);
  assign fc_nxt     = fc_full ? fc_r : fc_r + FC_W'(1);
  assign ovfs_nxt   = ovfs_r | fc_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
      fc_r   <= '0;
      ovfs_r <= 1'b0;
    end else if (in_beat && in_ch.opcode == OP_VERT) begin
      if (in_ch.last_face) begin
        for (int i = 0; i < 3; i++) sum_r[i] <= '0;
        fc_r   <= '0;
        ovfs_r <= 1'b0;
      end else begin
        for (int i = 0; i < 3; i++) sum_r[i] <= sum_nxt[i];
        fc_r   <= fc_nxt;
        ovfs_r <= ovfs_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic [63:0]      sqrt_t;
  logic             any_wide;
  logic [MAG_W-1:0] cmag [3];
  assign sqrt_t   = root_r + bit_r;
  assign any_wide = (|mag_r[0][MAG_W-1:SHF_LIM]) | (|mag_r[1][MAG_W-1:SHF_LIM]) |
                    (|mag_r[2][MAG_W-1:SHF_LIM]);

  // component magnitudes
  assign cmag[0] = magn(comp_r[0]);
  assign cmag[1] = magn(comp_r[1]);
  assign cmag[2] = magn(comp_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      launched_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            if (in_ch.opcode == OP_FACE) begin
              state_r <= ST_NMUL;
            end else if (in_ch.last_face) begin
              state_r    <= ST_VDIV;
              launched_r <= 1'b0;
            end
          end
        end
        ST_NMUL: if (ph_r && k_r == 2'd2 && edge_r == 2'd2) state_r <= ST_MAG;
        ST_VDIV: begin
          if (div_req.start) launched_r <= 1'b1;
          if (div_rsp.done) begin
            launched_r <= 1'b0;
            if (k_r == 2'd2) state_r <= ST_MAG;
          end
        end
        ST_MAG:  state_r <= ST_THR;
        ST_THR:  if (ph_r && k_r == 2'd3) state_r <= ST_DEC;
        ST_DEC:  state_r <= (big_r || sq_r > prod_r) ? ST_SHF : ST_FIN;
        ST_SHF:  if (!any_wide) state_r <= ST_SQ;
        ST_SQ:   if (ph_r && k_r == 2'd2) state_r <= ST_SQRT;
        ST_SQRT: begin
          if (bit_r[0]) begin
            state_r    <= ST_NDIV;
            launched_r <= 1'b0;
          end
        end
        ST_NDIV: begin
          if (div_req.start) launched_r <= 1'b1;
          if (div_rsp.done) begin
            launched_r <= 1'b0;
            if (k_r == 2'd2) state_r <= ST_FIN;
          end
        end
        ST_FIN:  if (out_free) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        k_r    <= '0;
        edge_r <= '0;
        ph_r   <= 1'b0;
        if (in_beat && in_ch.opcode == OP_FACE) begin
          crd_r[X0] <= sext_coord(in_ch.ax);
          crd_r[Y0] <= sext_coord(in_ch.ay);
          crd_r[Z0] <= sext_coord(in_ch.az);
          crd_r[X1] <= sext_coord(in_ch.bx);
          crd_r[Y1] <= sext_coord(in_ch.by_coord);
          crd_r[Z1] <= sext_coord(in_ch.bz);
          crd_r[X2] <= sext_coord(in_ch.cx);
          crd_r[Y2] <= sext_coord(in_ch.cy);
          crd_r[Z2] <= sext_coord(in_ch.cz);
          for (int i = 0; i < 3; i++) comp_r[i] <= '0;
          kind_r <= KIND_FACE;
          ovf_r  <= 1'b0;
        end else if (in_beat) begin
          for (int i = 0; i < 3; i++) begin
            comp_r[i] <= ACC_W'(sum_nxt[i]);
            mag_r[i]  <= magn(ACC_W'(sum_nxt[i]));
          end
          n_r    <= fc_nxt;
          kind_r <= KIND_VERT;
          ovf_r  <= ovfs_nxt;
        end
      end

      // Newell products, multiply then accumulate
      ST_NMUL: begin
        ph_r <= !ph_r;
        if (!ph_r) begin
          prod_r <= mul_p;
        end else begin
          comp_r[k_r] <= comp_r[k_r] + prod_r[ACC_W-1:0];
          if (edge_r == 2'd2) begin
            edge_r <= '0;
            k_r    <= k_r + 2'd1;
          end else begin
            edge_r <= edge_r + 2'd1;
          end
        end
      end

      // averaging divisions, one component at a time
      ST_VDIV: begin
        if (div_rsp.done) begin
          comp_r[k_r] <= cur_neg ? -ACC_W'(div_rsp.quo) : ACC_W'(div_rsp.quo);
          mag_r[k_r]  <= MAG_W'(div_rsp.quo);
          k_r         <= k_r + 2'd1;
        end
      end

      ST_MAG: begin
        for (int i = 0; i < 3; i++) mag_r[i] <= cmag[i];
        big_r <= (|cmag[0][MAG_W-1:BIG_LIM]) | (|cmag[1][MAG_W-1:BIG_LIM]) |
                 (|cmag[2][MAG_W-1:BIG_LIM]);
        sq_r  <= '0;
        k_r   <= '0;
        ph_r  <= 1'b0;
      end

      // three squares then the squared threshold
      ST_THR: begin
        ph_r <= !ph_r;
        if (!ph_r) begin
          prod_r <= mul_p;
        end else if (k_r != 2'd3) begin
          sq_r <= sq_r + prod_r;
          k_r  <= k_r + 2'd1;
        end
      end

      ST_DEC: begin
        raw_r <= !(big_r || sq_r > prod_r);
        for (int i = 0; i < 3; i++) res_r[i] <= raw_out(comp_r[i][ACC_W-1], mag_r[i], kind_r);
      end

      // bring all magnitudes below 2^30
      ST_SHF: begin
        if (any_wide) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end
        sq_r <= '0;
        k_r  <= '0;
        ph_r <= 1'b0;
      end

      ST_SQ: begin
        ph_r <= !ph_r;
        if (!ph_r) begin
          prod_r <= mul_p;
        end else begin
          sq_r <= sq_r + prod_r;
          k_r  <= k_r + 2'd1;
        end
        root_r <= '0;
        bit_r  <= 64'd1 << 62;
      end

      // bit-serial square root, two radicand bits per step
      ST_SQRT: begin
        if (sq_r[63:0] >= sqrt_t) begin
          sq_r   <= {2'b00, sq_r[63:0] - sqrt_t};
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        k_r   <= '0;
      end

      ST_NDIV: begin
        if (div_rsp.done) begin
          res_r[k_r] <= apply_sign(cur_neg, div_rsp.quo[OUT_W-1:0]);
          k_r        <= k_r + 2'd1;
        end
      end

      default: ph_r <= ph_r;
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      for (int i = 0; i < 3; i++) out_n_r[i] <= res_r[i];
      out_kind_r <= kind_r;
      out_raw_r  <= raw_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.norm_x         = out_n_r[0];
  assign out_ch.norm_y         = out_n_r[1];
  assign out_ch.norm_z         = out_n_r[2];
  assign out_ch.kind           = out_kind_r;
  assign out_ch.not_normalized = out_raw_r;
  assign out_ch.count_overflow = out_ovf_r;

endmodule

`default_nettype wire

### tb/sv/mfvn_checker.sv
// ----------------------------------------------------------------------------
// mfvn_checker
// Watches the item and result channels of the mesh normal block, predicts
// each result from the accepted items and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module mfvn_checker import mfvn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [CFG_W-1:0]  cfg_wdata,
  mfvn_in_if.sink           in_mon,
  mfvn_out_if.sink          out_mon,
  output int                fail_count,
  output int                pending_normals
);

  typedef struct packed {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    kind;
    logic                    raw;
    logic                    ovf;
  } normal_t;

  normal_t normal_q[$];

  // Predictor copy of the block's registers and running state
  logic [FMIN_W-1:0] face_thr;
  logic [VMIN_W-1:0] vert_thr;
  longint            acc_x, acc_y, acc_z;
  int unsigned       n_faces;
  bit                n_ovf;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sgn(longint r, longint unsigned m);
    return r < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  // Exact length above threshold, on 128-bit squares
  function automatic bit exceeds(longint c[3], longint unsigned thr);
    logic [127:0] s2;
    s2 = 0;
    for (int i = 0; i < 3; i++) s2 += 128'(mag(c[i])) * 128'(mag(c[i]));
    return s2 > 128'(thr) * 128'(thr);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale to unit length in Q1.16
  function automatic void unit_vec(longint c[3], output longint o[3]);
    longint unsigned m[3], s2, len;
    int sh;
    sh = 0;
    for (int i = 0; i < 3; i++) m[i] = mag(c[i]);
    while ((m[0] >> sh) >= 2**30 || (m[1] >> sh) >= 2**30 || (m[2] >> sh) >= 2**30) sh++;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= sh;
      s2 += m[i] * m[i];
    end
    len = int_sqrt(s2);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) o[i] = sgn(c[i], (m[i] * 65536 + len / 2) / len);
  endfunction

  function automatic longint sat24(longint v);
    return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
  endfunction

  task automatic predict_normal();
    longint c[3], o[3], x[3], y[3], z[3];
    longint unsigned n;
    int p;
    normal_t r;
    bit raw;
    r = '0;
    if (in_mon.opcode == OP_FACE) begin
      x[0] = sext_coord(in_mon.ax); y[0] = sext_coord(in_mon.ay); z[0] = sext_coord(in_mon.az);
      x[1] = sext_coord(in_mon.bx); y[1] = sext_coord(in_mon.by_coord);
      z[1] = sext_coord(in_mon.bz);
      x[2] = sext_coord(in_mon.cx); y[2] = sext_coord(in_mon.cy); z[2] = sext_coord(in_mon.cz);
      c = '{0, 0, 0};
      p = 2;
      for (int i = 0; i < 3; i++) begin
        c[0] += (y[p] - y[i]) * (z[p] + z[i]);
        c[1] += (z[p] - z[i]) * (x[p] + x[i]);
        c[2] += (x[p] - x[i]) * (y[p] + y[i]);
        p = i;
      end
      raw = !exceeds(c, face_thr);
      if (raw) begin
        for (int i = 0; i < 3; i++) o[i] = clip(sgn(c[i], (mag(c[i]) + 128) >> 8), 65536);
      end else begin
        unit_vec(c, o);
      end
      r.kind = KIND_FACE;
    end else begin
      acc_x = sat24(acc_x + longint'(in_mon.ax));
      acc_y = sat24(acc_y + longint'(in_mon.ay));
      acc_z = sat24(acc_z + longint'(in_mon.az));
      if (n_faces >= MAX_FACES) n_ovf = 1;
      else n_faces++;
      if (!in_mon.last_face) return;
      n = n_faces;
      c[0] = sgn(acc_x, (mag(acc_x) + n / 2) / n);
      c[1] = sgn(acc_y, (mag(acc_y) + n / 2) / n);
      c[2] = sgn(acc_z, (mag(acc_z) + n / 2) / n);
      raw = !exceeds(c, vert_thr);
      if (raw) begin
        for (int i = 0; i < 3; i++) o[i] = clip(c[i], 65536);
      end else begin
        unit_vec(c, o);
      end
      r.kind = KIND_VERT;
      r.ovf = n_ovf;
      acc_x = 0; acc_y = 0; acc_z = 0;
      n_faces = 0;
      n_ovf = 0;
    end
    r.nx = o[0][OUT_W-1:0];
    r.ny = o[1][OUT_W-1:0];
    r.nz = o[2][OUT_W-1:0];
    r.raw = raw;
    normal_q.push_back(r);
  endtask

  task automatic compare_normal();
    normal_t e;
    if (normal_q.size() == 0) begin
      $error("unexpected result beat");
      fail_count++;
      return;
    end
    e = normal_q.pop_front();
    if (out_mon.norm_x !== e.nx) begin
      $error("norm_x expected %0d got %0d", e.nx, out_mon.norm_x); fail_count++;
    end
    if (out_mon.norm_y !== e.ny) begin
      $error("norm_y expected %0d got %0d", e.ny, out_mon.norm_y); fail_count++;
    end
    if (out_mon.norm_z !== e.nz) begin
      $error("norm_z expected %0d got %0d", e.nz, out_mon.norm_z); fail_count++;
    end
    if (out_mon.kind !== e.kind) begin
      $error("kind expected %0d got %0d", e.kind, out_mon.kind); fail_count++;
    end
    if (out_mon.not_normalized !== e.raw) begin
      $error("not_normalized expected %0d got %0d", e.raw, out_mon.not_normalized);
      fail_count++;
    end
    if (out_mon.count_overflow !== e.ovf) begin
      $error("count_overflow expected %0d got %0d", e.ovf, out_mon.count_overflow);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  // Sample both channels and the register port at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      face_thr = 17;
      vert_thr = 0;
      acc_x = 0; acc_y = 0; acc_z = 0;
      n_faces = 0;
      n_ovf = 0;
      normal_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_FACE_MIN) face_thr = cfg_wdata[FMIN_W-1:0];
        else vert_thr = cfg_wdata[VMIN_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) compare_normal();
      if (in_mon.valid && in_mon.ready) predict_normal();
    end
    pending_normals = normal_q.size();
  end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives triangles and vertex face sequences into the mesh normal block
// under varying idle patterns and thresholds; the checker judges results.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mfvn_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending_normals;
  int               src_idle_pct;
  int               snk_idle_pct;
  int               quiet_cycles;

  mfvn_in_if  in_ch ();
  mfvn_out_if out_ch ();

  mesh_face_and_vertex_normals_top DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  mfvn_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending_normals(pending_normals)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // One beat; random idle cycles beforehand, held until accepted.
  // Valid is left high on return; the next beat replaces it or drain() drops it.
  task automatic send_beat(logic op, logic signed [CRD_W-1:0] v[9], logic lf);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.ax <= v[0]; in_ch.ay <= v[1]; in_ch.az <= v[2];
    in_ch.bx <= v[3]; in_ch.by_coord <= v[4]; in_ch.bz <= v[5];
    in_ch.cx <= v[6]; in_ch.cy <= v[7]; in_ch.cz <= v[8];
    in_ch.last_face <= lf;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic signed [CRD_W-1:0] rnd_coord();
    case ($urandom_range(4))
      0: return CRD_W'($urandom);
      1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      2: return $signed(24'($urandom_range(64))) - 24'sd32;
      default: return $signed(24'($urandom_range(65535))) - 24'sd32768;
    endcase
  endfunction

  task automatic send_triangle(int style);
    logic signed [CRD_W-1:0] v[9];
    for (int i = 0; i < 9; i++) v[i] = rnd_coord();
    if (style == 1) begin
      // degenerate: repeated vertex (b equals a)
      for (int i = 0; i < 3; i++) v[3 + i] = v[i];
    end
    send_beat(OP_FACE, v, $urandom_range(1));
  endtask

  // A vertex: a run of face normals of mixed scale, closed by last_face
  task automatic send_vertex(int faces);
    logic signed [CRD_W-1:0] v[9];
    for (int f = 0; f < faces; f++) begin
      for (int i = 0; i < 9; i++) v[i] = CRD_W'($urandom);
      case ($urandom_range(3))
        0: for (int i = 0; i < 3; i++) v[i] = CRD_W'($urandom);
        1: for (int i = 0; i < 3; i++) v[i] = $signed(24'($urandom_range(131072))) - 24'sd65536;
        2: for (int i = 0; i < 3; i++) v[i] = $signed(24'($urandom_range(40))) - 24'sd20;
        default: v[0:2] = '{24'sd65536, 24'sd0, -24'sd65536};
      endcase
      send_beat(OP_VERT, v, f == faces - 1);
    end
  endtask

  task automatic set_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Let the block finish: drop valid and wait for the expectation store to empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_normals != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic random_phase(int items);
    int k;
    k = 0;
    while (k < items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin send_triangle(0); k++; end
        4: begin send_triangle(1); k++; end
        5, 6, 7: begin
          int n;
          n = $urandom_range(1, 6);
          send_vertex(n);
          k += n;
        end
        8: begin
          int n;
          n = $urandom_range(7, 20);
          send_vertex(n);
          k += n;
        end
        default: begin send_vertex(66); k += 66; end
      endcase
    end
  endtask

  initial begin
    logic signed [CRD_W-1:0] v[9];
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = REG_FACE_MIN; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.opcode = OP_FACE; in_ch.last_face = 1'b0;
    in_ch.ax = '0; in_ch.ay = '0; in_ch.az = '0; in_ch.bx = '0; in_ch.by_coord = '0;
    in_ch.bz = '0; in_ch.cx = '0; in_ch.cy = '0; in_ch.cz = '0;
    out_ch.ready = 1'b0;
    src_idle_pct = 26; snk_idle_pct = 61; quiet_cycles = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, zero triangle, tiny triangles, vertices of 1, 2, 64 and 65 faces
    v = '{default: 24'sd0};
    send_beat(OP_FACE, v, 1'b0);
    v = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
          24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF};
    send_beat(OP_FACE, v, 1'b1);
    v = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
          24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000};
    send_beat(OP_FACE, v, 1'b0);
    v = '{24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0};
    send_beat(OP_FACE, v, 1'b0);
    v = '{24'sd0, 24'sd0, 24'sd0, 24'sd4096, 24'sd0, 24'sd0, 24'sd0, 24'sd4096, 24'sd0};
    send_beat(OP_FACE, v, 1'b0);
    v = '{default: 24'sd0};
    send_beat(OP_VERT, v, 1'b1);
    v = '{default: 24'sh7FFFFF};
    send_beat(OP_VERT, v, 1'b0);
    send_beat(OP_VERT, v, 1'b1);
    v = '{default: 24'sh800000};
    send_beat(OP_VERT, v, 1'b0);
    send_beat(OP_VERT, v, 1'b1);
    send_vertex(1);
    send_vertex(64);
    send_vertex(65);
    drain();

    // Threshold settings, extremes included, across idle patterns
    src_idle_pct = 26; snk_idle_pct = 61;
    set_reg(REG_FACE_MIN, 32'hFFFF_FFFF);
    set_reg(REG_VERT_MIN, 32'd65536);
    random_phase(120);
    drain();
    set_reg(REG_FACE_MIN, 32'd0);
    set_reg(REG_VERT_MIN, 32'd0);
    random_phase(160);
    drain();
    src_idle_pct = 61; snk_idle_pct = 26;
    set_reg(REG_FACE_MIN, 32'd1 << 24);
    set_reg(REG_VERT_MIN, 32'd30000);
    random_phase(200);
    drain();
    src_idle_pct = 0; snk_idle_pct = 0;
    set_reg(REG_FACE_MIN, 32'd17);
    set_reg(REG_VERT_MIN, 32'd20);
    random_phase(200);
    drain();
    set_reg(REG_FACE_MIN, $urandom);
    set_reg(REG_VERT_MIN, $urandom_range(65536));
    random_phase(200);
    drain();

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/mfvn_pkg.sv
design/mfvn_chan_if.sv
design/mfvn_div.sv
design/mesh_face_and_vertex_normals_top.sv
tb/sv/mfvn_checker.sv
tb/sv/testbench.sv
